// File: src/fcr_pkg.sv
// Shared types and codes for the circular FIFO with reverse.
package fcr_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic swap_rd;
    logic swap_wlo;
    logic swap_whi;
    logic load_out;
  } fcr_cmd_t;

  typedef struct packed {
    logic rev_go;
    logic last_pair;
  } fcr_stat_t;

endpackage

// File: src/fcr_in_if.sv
// Request channel: opcode and push value with valid/ready.
interface fcr_in_if
  import fcr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// File: src/fcr_out_if.sv
// Result channel: front value, count, flags and status with valid/ready.
interface fcr_out_if
  import fcr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  front_value;
  logic                front_valid;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_empty;
  logic                is_full;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output front_value, output front_valid, output entry_count,
                  output is_empty, output is_full, output status, input ready);
  modport sink   (input valid, input front_value, input front_valid, input entry_count,
                  input is_empty, input is_full, input status, output ready);
endinterface

// File: src/fcr_ram.sv
// Generic RAM: one write port, two registered read ports.
module fcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: src/fcr_ctrl.sv
// Controller: sequences request handling, swap passes and result load.
module fcr_ctrl
  import fcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  fcr_stat_t stat,
  output fcr_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SRD   = 6'b000010,
    S_SWLO  = 6'b000100,
    S_SWHI  = 6'b001000,
    S_FRONT = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.swap_rd  = (state_r == S_SRD);
    cmd.swap_wlo = (state_r == S_SWLO);
    cmd.swap_whi = (state_r == S_SWHI);
    cmd.load_out = (state_r == S_RESP) && can_load;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.rev_go ? S_SRD : S_FRONT;
        end
      end
      S_SRD:   state_nxt = S_SWLO;
      S_SWLO:  state_nxt = S_SWHI;
      S_SWHI:  state_nxt = stat.last_pair ? S_FRONT : S_SRD;
      S_FRONT: state_nxt = S_RESP;
      S_RESP: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: src/fcr_datapath.sv
// Datapath: ring pointers, count, slot RAM, swap registers and result register.
module fcr_datapath
  import fcr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcr_cmd_t            cmd,
  output fcr_stat_t           stat,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [VALUE_W-1:0]  in_push_value,
  output logic [VALUE_W-1:0]  out_front_value,
  output logic                out_front_valid,
  output logic [COUNT_W-1:0]  out_entry_count,
  output logic                out_is_empty,
  output logic                out_is_full,
  output logic [STATUS_W-1:0] out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = CW - 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  logic [AW-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [PW-1:0]     pairs_r, pairs_nxt;
  status_t           status_r, status_nxt;
  logic [WORD_WIDTH-1:0] tmp_r;
  op_t               op;
  logic              empty, full;

  logic                  we;
  logic [AW-1:0]         waddr, raddr_a;
  logic [WORD_WIDTH-1:0] wdata, rdata_a, rdata_b;
  logic [63:0]           rd64;

  assign op    = op_t'(in_opcode);
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));

  assign stat.rev_go    = (op == OP_REVERSE) && (count_r > CW'(1));
  assign stat.last_pair = (pairs_r == PW'(1));

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pairs_nxt  = pairs_r;
    we         = 1'b0;
    waddr      = tail_r;
    wdata      = WORD_WIDTH'(in_push_value);
    if (cmd.accept) begin
      status_nxt = ST_OK;
      lo_nxt     = head_r;
      hi_nxt     = tail_r;
      pairs_nxt  = count_r[CW-1:1];
      unique case (op)
        OP_PUSH: begin
          if (full) begin
            status_nxt = ST_PUSH_FULL;
          end else begin
            tail_nxt  = ring_next(tail_r);
            count_nxt = count_r + 1'b1;
            we        = 1'b1;
            waddr     = ring_next(tail_r);
          end
        end
        OP_POP: begin
          if (empty) begin
            status_nxt = ST_POP_EMPTY;
          end else begin
            head_nxt  = ring_next(head_r);
            count_nxt = count_r - 1'b1;
          end
        end
        OP_REVERSE, OP_QUERY: begin
        end
        default: begin
        end
      endcase
    end
    if (cmd.swap_wlo) begin
      we    = 1'b1;
      waddr = lo_r;
      wdata = rdata_b;
    end
    if (cmd.swap_whi) begin
      we        = 1'b1;
      waddr     = hi_r;
      wdata     = tmp_r;
      lo_nxt    = ring_next(lo_r);
      hi_nxt    = ring_prev(hi_r);
      pairs_nxt = pairs_r - 1'b1;
    end
  end

  assign raddr_a = (cmd.swap_rd || cmd.swap_wlo) ? lo_r : head_r;

  fcr_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (hi_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign rd64 = 64'(rdata_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= AW'(1);
      tail_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    pairs_r <= pairs_nxt;
    if (cmd.swap_wlo) begin
      tmp_r <= rdata_a;
    end
    if (cmd.load_out) begin
      out_front_value <= empty ? '0 : rd64[VALUE_W-1:0];
      out_front_valid <= !empty;
      out_entry_count <= COUNT_W'(count_r);
      out_is_empty    <= empty;
      out_is_full     <= full;
      out_status      <= status_r;
    end
  end

endmodule

// File: src/circular_fifo_with_reverse.sv
// Circular FIFO with in-place reverse: top level.
// Each request takes one opcode (push, pop, reverse, query) and returns one result
// describing the FIFO afterwards. Push, pop and query go from the accepting state through
// a registered RAM read of the front entry to the load of the result register; reverse
// first runs one read-write-write pass per swapped pair, floor(count/2) pairs, through
// the single write port of the slot RAM. The result load waits while the output
// register still holds an untaken result. One request is in flight at a time; a
// new request is accepted while the previous result still waits in the output register.
// Slot contents are undefined until written, so no clearing pass runs after reset.
module circular_fifo_with_reverse
  import fcr_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  fcr_in_if.sink    in_ch,
  fcr_out_if.source out_ch
);

  fcr_cmd_t  cmd;
  fcr_stat_t stat;

  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcr_datapath #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_ch.opcode),
    .in_push_value   (in_ch.push_value),
    .out_front_value (out_ch.front_value),
    .out_front_valid (out_ch.front_valid),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .out_is_full     (out_ch.is_full),
    .out_status      (out_ch.status)
  );

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while previous one in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten before taken");

  a_swap_lo_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_wlo |-> $past(cmd.swap_rd))
    else $error("swap write without preceding read");

  a_swap_hi_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap_whi |-> $past(cmd.swap_wlo))
    else $error("swap second write out of order");
`endif

endmodule
